// ===== hw/rtl/trmp_pkg.sv =====
// Package for the torque meter reply parser: result record, character codes,
// status and kind codes, and the prefix and power-of-ten lookup functions.
// No dependencies.
package trmp_pkg;

    typedef struct packed {
        logic [1:0]         status;
        logic [3:0]         kind;
        logic signed [31:0] first;
        logic signed [31:0] second;
        logic signed [31:0] intv;
        logic [6:0]         flags;
    } result_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_BUSY    = 2'd2;

    localparam logic [3:0] KIND_RD     = 4'd2;
    localparam logic [3:0] KIND_STATUS = 4'd3;
    localparam logic [3:0] KIND_RH     = 4'd4;
    localparam logic [3:0] KIND_RI     = 4'd5;
    localparam logic [3:0] KIND_RK     = 4'd7;
    localparam logic [3:0] KIND_W32    = 4'd8;
    localparam logic [3:0] KIND_W41    = 4'd9;
    localparam logic [3:0] KIND_COUNT  = 4'd11;

    localparam logic [1:0] FT_DEC = 2'd0;
    localparam logic [1:0] FT_INT = 2'd1;
    localparam logic [1:0] FT_UNS = 2'd2;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_E     = 8'h45;
    localparam logic [7:0] CH_R     = 8'h52;
    localparam logic [7:0] CH_W     = 8'h57;

    localparam logic [7:0] TERM_RESET = 8'd13;

    function automatic logic [7:0] prefix_char(input logic [3:0] kind, input logic [1:0] idx);
        logic [7:0] c;
        c = 8'h00;
        if (kind >= KIND_W32) begin
            case (idx)
                2'd0: c = CH_W;
                2'd1: c = (kind == KIND_W32) ? 8'h33 : 8'h34;
                2'd2: c = (kind == KIND_W41) ? 8'h31 : 8'h32;
                default: c = 8'h00;
            endcase
        end else begin
            case (idx)
                2'd0: c = CH_R;
                2'd1:
                begin
                    case (kind)
                        4'd0: c = 8'h41;
                        4'd1: c = 8'h42;
                        4'd2: c = 8'h44;
                        4'd3: c = 8'h45;
                        4'd4: c = 8'h48;
                        4'd5: c = 8'h49;
                        4'd6: c = 8'h4A;
                        4'd7: c = 8'h4B;
                        default: c = 8'h00;
                    endcase
                end
                default: c = 8'h00;
            endcase
        end
        return c;
    endfunction

    function automatic logic [19:0] pow10(input logic [2:0] n);
        logic [19:0] p;
        case (n)
            3'd0: p = 20'd1;
            3'd1: p = 20'd10;
            3'd2: p = 20'd100;
            3'd3: p = 20'd1000;
            3'd4: p = 20'd10000;
            3'd5: p = 20'd100000;
            3'd6: p = 20'd1000000;
            default: p = 20'd0;
        endcase
        return p;
    endfunction

endpackage

// ===== hw/rtl/trmp_core.sv =====
// Line state and per-byte update of the torque meter reply parser.
// Depends on trmp_pkg; produces at most one result per accepted transaction.
module trmp_core #(
    parameter int LINE_MAX    = 64,
    parameter int FRAC_DIGITS = 3
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic                 func,
    input  logic [3:0]           reply_kind,
    input  logic [7:0]           rx_byte,
    input  logic [7:0]           term,
    output logic                 res_valid,
    output trmp_pkg::result_t    res
);
    import trmp_pkg::*;

    localparam int CW = $clog2(LINE_MAX);

    logic          armed_reg, armed_next;
    logic [3:0]    kind_reg, kind_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [1:0]    pp_reg, pp_next;
    logic [1:0]    fidx_reg, fidx_next;
    logic          neg_reg, neg_next;
    logic          digit_reg, digit_next;
    logic          dot_reg, dot_next;
    logic          started_reg, started_next;
    logic [2:0]    fc_reg, fc_next;
    logic [31:0]   acc_reg, acc_next;
    logic [31:0]   first_reg, first_next;
    logic [31:0]   second_reg, second_next;
    logic [6:0]    flags_reg, flags_next;
    logic          bad_reg, bad_next;
    logic [1:0]    erm_reg, erm_next;

    always_comb
    begin
        logic [1:0]    pl;
        logic [1:0]    total;
        logic [1:0]    ftype;
        logic          match;
        logic          partial;
        logic          bad_eff;
        logic [CW-1:0] ppos;
        logic [35:0]   sum;
        logic [35:0]   lim;
        logic [3:0]    d;
        logic [31:0]   sval;
        logic [6:0]    mx;
        logic          clear;

        armed_next   = armed_reg;
        kind_next    = kind_reg;
        cnt_next     = cnt_reg;
        pp_next      = pp_reg;
        fidx_next    = fidx_reg;
        neg_next     = neg_reg;
        digit_next   = digit_reg;
        dot_next     = dot_reg;
        started_next = started_reg;
        fc_next      = fc_reg;
        acc_next     = acc_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        flags_next   = flags_reg;
        bad_next     = bad_reg;
        erm_next     = erm_reg;
        res_valid    = 1'b0;
        res          = '0;
        res.status   = ST_INVALID;
        res.kind     = kind_reg;
        clear        = 1'b0;

        pl    = (kind_reg >= KIND_W32) ? 2'd3 : 2'd2;
        total = (kind_reg == KIND_RH) ? 2'd2 :
                ((kind_reg == KIND_RI || kind_reg == KIND_RK) ? 2'd3 : 2'd1);
        if (kind_reg == KIND_RD) begin
            ftype = FT_INT;
        end else if (kind_reg >= KIND_W32) begin
            ftype = FT_UNS;
        end else if ((kind_reg == KIND_RI || kind_reg == KIND_RK) && fidx_reg >= 2'd2) begin
            ftype = FT_INT;
        end else begin
            ftype = FT_DEC;
        end
        sval    = neg_reg ? (32'd0 - acc_reg) : acc_reg;
        partial = (pp_reg != 2'd0) && (pp_reg < pl);
        match   = ({{(CW-2){1'b0}}, pp_reg} == cnt_reg) && (pp_reg < pl) &&
                  (rx_byte == prefix_char(kind_reg, pp_reg));
        bad_eff = bad_reg || (partial && kind_reg != KIND_STATUS);
        ppos    = (partial && kind_reg == KIND_STATUS) ? cnt_reg
                  : cnt_reg - {{(CW-2){1'b0}}, pp_reg};
        lim     = neg_reg ? 36'h080000000 : 36'h07FFFFFFF;
        d       = rx_byte[3:0];
        sum     = '0;
        mx      = (kind_reg == KIND_W32) ? 7'd7 : ((kind_reg == KIND_W41) ? 7'd5 : 7'd99);

        if (go) begin
            if (!func) begin
                if (armed_reg) begin
                    res_valid  = 1'b1;
                    res.status = ST_BUSY;
                    res.kind   = reply_kind;
                end else if (reply_kind >= KIND_COUNT) begin
                    res_valid  = 1'b1;
                    res.kind   = reply_kind;
                end else begin
                    armed_next = 1'b1;
                    kind_next  = reply_kind;
                    clear      = 1'b1;
                end
            end else if (armed_reg && rx_byte != CH_LF) begin
                if (rx_byte == term) begin
                    res_valid  = 1'b1;
                    armed_next = 1'b0;
                    clear      = 1'b1;
                    if (!(bad_reg || erm_reg == 2'd2 || partial)) begin
                        if (kind_reg == KIND_STATUS) begin
                            if (cnt_reg - {{(CW-2){1'b0}}, pp_reg} == CW'(7)) begin
                                res.status = ST_OK;
                                res.flags  = flags_reg;
                            end
                        end else if (digit_reg && (fidx_reg + 2'd1 == total) &&
                                     !(ftype == FT_UNS && acc_reg > {25'd0, mx})) begin
                            res.status = ST_OK;
                            if (kind_reg == KIND_RD) begin
                                res.intv = sval;
                            end else if (kind_reg == KIND_RH) begin
                                res.first  = first_reg;
                                res.second = sval;
                            end else if (kind_reg == KIND_RI || kind_reg == KIND_RK) begin
                                res.first  = first_reg;
                                res.second = second_reg;
                                res.intv   = sval;
                            end else begin
                                res.first = sval;
                            end
                        end
                    end
                end else if ({1'b0, cnt_reg} + (CW+1)'(1) >= (CW+1)'(LINE_MAX)) begin
                    res_valid = 1'b1;
                    clear     = 1'b1;
                end else begin
                    cnt_next = cnt_reg + CW'(1);
                    if (cnt_reg == '0) begin
                        erm_next = (rx_byte == CH_E) ? 2'd1 : 2'd3;
                    end else if (cnt_reg == CW'(1)) begin
                        erm_next = (erm_reg == 2'd1 && rx_byte == CH_R) ? 2'd2 : 2'd3;
                    end else begin
                        erm_next = 2'd3;
                    end
                    if (match) begin
                        pp_next = pp_reg + 2'd1;
                    end else begin
                        if (partial) begin
                            if (kind_reg == KIND_STATUS) begin
                                pp_next = 2'd0;
                            end else begin
                                bad_next = 1'b1;
                            end
                        end
                        if (kind_reg == KIND_STATUS) begin
                            if (ppos < CW'(7) && rx_byte == CH_ONE) begin
                                flags_next[ppos[2:0]] = 1'b1;
                            end
                        end else if (!bad_eff) begin
                            if (rx_byte == CH_COMMA) begin
                                if (!digit_reg || fidx_reg + 2'd1 >= total) begin
                                    bad_next = 1'b1;
                                end else begin
                                    if (fidx_reg == 2'd0) begin
                                        first_next = sval;
                                    end else begin
                                        second_next = sval;
                                    end
                                    fidx_next    = fidx_reg + 2'd1;
                                    neg_next     = 1'b0;
                                    digit_next   = 1'b0;
                                    dot_next     = 1'b0;
                                    started_next = 1'b0;
                                    fc_next      = 3'd0;
                                    acc_next     = 32'd0;
                                end
                            end else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE) begin
                                if (ftype == FT_DEC && dot_reg) begin
                                    if (int'(fc_reg) < FRAC_DIGITS) begin
                                        sum = {4'd0, acc_reg} + 36'(d * pow10(3'(FRAC_DIGITS
                                              - int'(fc_reg) - 1)));
                                        acc_next = (sum > lim) ? lim[31:0] : sum[31:0];
                                        fc_next  = fc_reg + 3'd1;
                                    end
                                end else begin
                                    if (ftype == FT_DEC) begin
                                        sum = {acc_reg, 3'd0} + {3'd0, acc_reg, 1'b0}
                                              + 36'(d * pow10(3'(FRAC_DIGITS)));
                                    end else begin
                                        sum = {acc_reg, 3'd0} + {3'd0, acc_reg, 1'b0}
                                              + {32'd0, d};
                                    end
                                    acc_next = (sum > lim) ? lim[31:0] : sum[31:0];
                                end
                                digit_next   = 1'b1;
                                started_next = 1'b1;
                            end else if (rx_byte == CH_PLUS || rx_byte == CH_MINUS) begin
                                if (started_reg || ftype == FT_UNS) begin
                                    bad_next = 1'b1;
                                end else begin
                                    started_next = 1'b1;
                                    neg_next     = (rx_byte == CH_MINUS);
                                end
                            end else if (rx_byte == CH_DOT) begin
                                if (ftype != FT_DEC || dot_reg) begin
                                    bad_next = 1'b1;
                                end else begin
                                    dot_next     = 1'b1;
                                    started_next = 1'b1;
                                end
                            end else begin
                                bad_next = 1'b1;
                            end
                        end
                    end
                end
            end
        end

        if (clear) begin
            cnt_next     = '0;
            pp_next      = 2'd0;
            fidx_next    = 2'd0;
            neg_next     = 1'b0;
            digit_next   = 1'b0;
            dot_next     = 1'b0;
            started_next = 1'b0;
            fc_next      = 3'd0;
            acc_next     = 32'd0;
            first_next   = 32'd0;
            second_next  = 32'd0;
            flags_next   = 7'd0;
            bad_next     = 1'b0;
            erm_next     = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            armed_reg   <= 1'b0;
            kind_reg    <= 4'd0;
            cnt_reg     <= '0;
            pp_reg      <= 2'd0;
            fidx_reg    <= 2'd0;
            neg_reg     <= 1'b0;
            digit_reg   <= 1'b0;
            dot_reg     <= 1'b0;
            started_reg <= 1'b0;
            fc_reg      <= 3'd0;
            acc_reg     <= 32'd0;
            first_reg   <= 32'd0;
            second_reg  <= 32'd0;
            flags_reg   <= 7'd0;
            bad_reg     <= 1'b0;
            erm_reg     <= 2'd0;
        end else begin
            armed_reg   <= armed_next;
            kind_reg    <= kind_next;
            cnt_reg     <= cnt_next;
            pp_reg      <= pp_next;
            fidx_reg    <= fidx_next;
            neg_reg     <= neg_next;
            digit_reg   <= digit_next;
            dot_reg     <= dot_next;
            started_reg <= started_next;
            fc_reg      <= fc_next;
            acc_reg     <= acc_next;
            first_reg   <= first_next;
            second_reg  <= second_next;
            flags_reg   <= flags_next;
            bad_reg     <= bad_next;
            erm_reg     <= erm_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_armed_kind: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg |-> kind_reg < KIND_COUNT)
        else $error("Armed with an unknown reply kind.");
    a_busy_armed: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.status == ST_BUSY) |-> armed_reg)
        else $error("Busy result while idle.");
    a_term_disarm: assert property (@(posedge clk) disable iff (!rst_n)
        (go && func && armed_reg && rx_byte == term && rx_byte != CH_LF) |=> !armed_reg)
        else $error("Terminator did not disarm.");
`endif

endmodule

// ===== hw/rtl/torque_meter_reply_parser_top.sv =====
// Top level of the torque meter reply parser: terminator register, parser
// core and a two-entry result queue. Depends on trmp_pkg and trmp_core.
//
// Channel  Direction  Handshake           Payload
// in       to block   in_valid/in_stall   func, reply_kind, rx_byte
// out      from block out_valid/out_stall result_status ... status_flags
// cfg      to block   cfg_valid/cfg_ready cfg_data (line terminator)
//
// Each transaction is handled as it is taken and its result is registered in
// the output register or the skid entry, which hold one result each. One input
// transaction is taken every cycle while in_stall is low; in_stall rises only
// when both are occupied. Reset sets the block idle and the terminator to 13.
module torque_meter_reply_parser_top #(
    parameter int LINE_MAX    = 64,
    parameter int FRAC_DIGITS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               func,
    input  logic [3:0]         reply_kind,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_status,
    output logic [3:0]         result_kind,
    output logic signed [31:0] first_value,
    output logic signed [31:0] second_value,
    output logic signed [31:0] int_value,
    output logic [6:0]         status_flags,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import trmp_pkg::*;

    logic    [7:0] term_reg;
    logic          out_valid_reg;
    logic          skid_valid_reg;
    result_t       out_data_reg;
    result_t       skid_data_reg;
    logic          res_valid;
    result_t       res;
    logic          go;
    logic          slot_free;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign go        = in_valid && !skid_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    trmp_core #(
        .LINE_MAX    (LINE_MAX),
        .FRAC_DIGITS (FRAC_DIGITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .go         (go),
        .func       (func),
        .reply_kind (reply_kind),
        .rx_byte    (rx_byte),
        .term       (term_reg),
        .res_valid  (res_valid),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            term_reg       <= TERM_RESET;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                term_reg <= cfg_data;
            end
            if (slot_free) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= res_valid;
                end else begin
                    out_valid_reg <= res_valid;
                end
            end else if (res_valid) begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free) begin
            if (skid_valid_reg) begin
                out_data_reg  <= skid_data_reg;
                skid_data_reg <= res;
            end else begin
                out_data_reg <= res;
            end
        end else if (res_valid) begin
            skid_data_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign result_status = out_data_reg.status;
    assign result_kind   = out_data_reg.kind;
    assign first_value   = out_data_reg.first;
    assign second_value  = out_data_reg.second;
    assign int_value     = out_data_reg.intv;
    assign status_flags  = out_data_reg.flags;

`ifndef NO_ASSERTIONS
    a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid entry holds a result ahead of the output register.");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("Stalled result was dropped.");
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> out_valid_reg)
        else $error("Skid entry was lost.");
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (result_status != 2'd3))
        else $error("Unknown result status.");
`endif

endmodule
